// ===== sv/cdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter package
// Shared constants and calendar lookup functions for the date counter.
// ----------------------------------------------------------------------------
package cdc_pkg;

    localparam int unsigned COUNT_MAX = 65535;
    localparam int unsigned YEAR_MAX  = 9999;

    // Operation codes carried in tuser
    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 14;
    localparam int DOY_W   = 9;
    localparam int CNT_W   = 16;
    localparam int TOTAL_W = 17;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    typedef logic [MONTH_W-1:0] t_month;
    typedef logic [DAY_W-1:0]   t_day;
    typedef logic [YEAR_W-1:0]  t_year;
    typedef logic [DOY_W-1:0]   t_doy;

    // Days in a month, given the leap flag of its year
    function automatic t_day month_len(input t_month m, input logic leap);
        t_day len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the months before month m of a common year
    function automatic t_doy days_before(input t_month m);
        t_doy d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/calendar_date_counter_unit.sv =====
`timescale 1ns / 1ps
// Sequence: set recomputes the leap flag, then checks the day; subtract steps back
//   directly, or recomputes the leap flag when it crosses into the previous year;
//   add subtracts one month length per cycle, with a leap update per year crossed.
// Throughput: one transaction at a time; the input is not ready while a date
//   operation runs or a result waits to be taken.
// Reset: synchronous active low; the date returns to 1/1/2000.
// ----------------------------------------------------------------------------
// Calendar date counter
// Holds a Gregorian date; sets, advances by a day count or steps back one day,
// reporting the date, the day of the year and the days left in the year.
// ----------------------------------------------------------------------------
module calendar_date_counter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // new_month[3:0], new_day[8:4], new_year[22:9], day_count[38:23], zero pad
    input  logic [cdc_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // operation[1:0]
    input  logic [cdc_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // cur_month[3:0], cur_day[8:4], cur_year[22:9], day_of_year[31:23],
    // days_remaining[40:32], field_error[41], range_error[42], zero pad
    output logic [cdc_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);
    import cdc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_LEAP1  = 3'd2;
    localparam logic [2:0] S_LEAP2  = 3'd3;
    localparam logic [2:0] S_SETDAY = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SH for 14-bit y
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          DIV100_SH  = 19;
    localparam int          PROD_W     = YEAR_W + 13;

    localparam t_year              C_YEAR_MAX  = YEAR_MAX[YEAR_W-1:0];
    localparam logic [CNT_W-1:0]   C_COUNT_MAX = COUNT_MAX[CNT_W-1:0];

    logic [2:0]          r_state;
    logic [2:0]          r_ret;
    t_month              r_month;
    t_day                r_day;
    t_year               r_year;
    logic                r_leap;
    logic [6:0]          r_q;
    t_day                r_new_day;
    logic [TOTAL_W-1:0]  r_total;
    logic                r_ferr;
    logic                r_rerr;
    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic                w_accept;
    logic [1:0]          w_op;
    t_month              w_in_month;
    t_day                w_in_day;
    t_year               w_in_year;
    logic [CNT_W-1:0]    w_in_count;
    logic [CNT_W-1:0]    w_count;
    t_day                w_len;
    t_day                w_prev_len;
    logic [PROD_W-1:0]   w_prod;
    t_year               w_rem100;
    t_doy                w_doy;
    t_doy                w_left;

    assign w_op       = i_s_axis_tuser[1:0];
    assign w_in_month = i_s_axis_tdata[3:0];
    assign w_in_day   = i_s_axis_tdata[8:4];
    assign w_in_year  = i_s_axis_tdata[22:9];
    assign w_in_count = i_s_axis_tdata[38:23];

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_count = ({16'd0, w_in_count} > COUNT_MAX) ? C_COUNT_MAX : w_in_count;

    // Month-length lookups for the current month and the month before it
    assign w_len      = month_len(r_month, r_leap);
    assign w_prev_len = month_len(r_month - 4'd1, r_leap);

    assign w_prod   = r_year * DIV100_MUL;
    assign w_rem100 = r_year - t_year'(r_q) * 14'd100;

    assign w_doy  = days_before(r_month) + t_doy'(r_day)
                  + t_doy'(r_leap && (r_month > 4'd2));
    assign w_left = (r_leap ? 9'd366 : 9'd365) - w_doy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_DONE;
            r_month     <= 4'd1;
            r_day       <= 5'd1;
            r_year      <= 14'd2000;
            r_leap      <= 1'b1;
            r_ferr      <= 1'b0;
            r_rerr      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        priority if (w_op == OP_SET) begin
                            if (w_in_month < 4'd1 || w_in_month > 4'd12) begin
                                r_month <= 4'd1;
                                r_ferr  <= 1'b1;
                            end else begin
                                r_month <= w_in_month;
                                r_ferr  <= 1'b0;
                            end
                            if (w_in_year > C_YEAR_MAX) begin
                                r_year <= C_YEAR_MAX;
                                r_rerr <= 1'b1;
                            end else begin
                                r_year <= w_in_year;
                                r_rerr <= 1'b0;
                            end
                            r_new_day <= w_in_day;
                            r_ret     <= S_SETDAY;
                            r_state   <= S_LEAP1;
                        end else if (w_op == OP_ADD) begin
                            r_ferr  <= 1'b0;
                            r_rerr  <= 1'b0;
                            r_total <= TOTAL_W'(r_day) + TOTAL_W'(w_count);
                            r_state <= S_WALK;
                        end else if (w_op == OP_SUB) begin
                            r_ferr <= 1'b0;
                            priority if (r_day > 5'd1) begin
                                r_day   <= r_day - 5'd1;
                                r_rerr  <= 1'b0;
                                r_state <= S_DONE;
                            end else if (r_month > 4'd1) begin
                                r_month <= r_month - 4'd1;
                                r_day   <= w_prev_len;
                                r_rerr  <= 1'b0;
                                r_state <= S_DONE;
                            end else if (r_year > 14'd0) begin
                                r_year  <= r_year - 14'd1;
                                r_month <= 4'd12;
                                r_day   <= 5'd31;
                                r_rerr  <= 1'b0;
                                r_ret   <= S_DONE;
                                r_state <= S_LEAP1;
                            end else begin
                                r_rerr  <= 1'b1;
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_ferr  <= 1'b0;
                            r_rerr  <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_WALK: begin
                    // Subtract a month per cycle (new years pause for leap) until day fits or year limit
                    priority if (r_total <= TOTAL_W'(w_len)) begin
                        r_day   <= r_total[DAY_W-1:0];
                        r_state <= S_DONE;
                    end else if (r_month == 4'd12 && r_year >= C_YEAR_MAX) begin
                        r_day   <= 5'd31;
                        r_rerr  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_total <= r_total - TOTAL_W'(w_len);
                        if (r_month == 4'd12) begin
                            r_month <= 4'd1;
                            r_year  <= r_year + 14'd1;
                            r_ret   <= S_WALK;
                            r_state <= S_LEAP1;
                        end else begin
                            r_month <= r_month + 4'd1;
                        end
                    end
                end
                S_LEAP1: begin
                    r_q     <= w_prod[DIV100_SH +: 7];
                    r_state <= S_LEAP2;
                end
                S_LEAP2: begin
                    r_leap  <= (r_year[1:0] == 2'd0)
                            && ((w_rem100 != 14'd0) || (r_q[1:0] == 2'd0));
                    r_state <= r_ret;
                end
                S_SETDAY: begin
                    if (r_new_day < 5'd1 || r_new_day > w_len) begin
                        r_day  <= 5'd1;
                        r_ferr <= 1'b1;
                    end else begin
                        r_day  <= r_new_day;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out_data  <= {5'd0, r_rerr, r_ferr, w_left, w_doy,
                                    r_year, r_day, r_month};
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
